/* hw/rtl/lds_pkg.sv */
// lds_pkg: payload structs, register indexes and segment constants for the
// led digit scan driver. No dependencies.
package lds_pkg;

  typedef struct packed {
    logic       action;
    logic [2:0] digit_index;
    logic [7:0] segment_value;
    logic       test_mode;
    logic       hold_at_wrap;
  } lds_in_t;

  typedef struct packed {
    logic [2:0] blank_digit;
    logic [7:0] segment_drive;
    logic [2:0] active_digit;
  } lds_out_t;

  // outcome of the next-digit search
  typedef struct packed {
    logic       found;
    logic [2:0] digit;
  } lds_sel_t;

  localparam logic       ACT_TICK  = 1'b0;
  localparam logic       ACT_WRITE = 1'b1;

  localparam logic [1:0] REG_DIGIT_EN  = 2'd0;
  localparam logic [1:0] REG_DIM_EN    = 2'd1;
  localparam logic [1:0] REG_HALF_BRT  = 2'd2;

  localparam logic [7:0] SEG_ALL_ON  = 8'hff;
  localparam logic [7:0] SEG_BLANK   = 8'h00;

endpackage

/* hw/rtl/lds_ram.sv */
// lds_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/lds_scan.sv */
// lds_scan: next enabled digit search after the current digit, with wrap
// back to the lowest enabled digit unless held. Depends on lds_pkg.
module lds_scan import lds_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  logic [2:0] cur_digit,
  input  logic [7:0] enable_mask,
  input  logic       hold,
  output lds_sel_t   sel
);

  logic       up_found;
  logic [2:0] up_digit;
  logic       lo_found;
  logic [2:0] lo_digit;

  // walk downward so the lowest qualifying digit wins
  always_comb begin
    up_found = 1'b0;
    up_digit = '0;
    lo_found = 1'b0;
    lo_digit = '0;
    for (int d = DIGITS - 1; d >= 0; d--) begin
      if (enable_mask[d]) begin
        lo_found = 1'b1;
        lo_digit = 3'(d);
        if (3'(d) > cur_digit) begin
          up_found = 1'b1;
          up_digit = 3'(d);
        end
      end
    end
    sel.found = up_found || (!hold && lo_found);
    sel.digit = up_found ? up_digit : lo_digit;
  end

endmodule

/* hw/rtl/led_digit_scan_driver.sv */
// led_digit_scan_driver: multiplexed led digit scanner, segment bytes in a RAM.
// Depends on lds_pkg, lds_ram, lds_scan.
// Driving tick: the segment RAM is read at acceptance and the output register is
// loaded from the read data in ST_READ, once out is not stalled.
// Input: writes and silent ticks keep in_ready high; a driving tick holds it low until the output is loaded.
// Reset: synchronous; digit valid bits cleared so every digit reads as zero.
module led_digit_scan_driver import lds_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lds_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lds_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state;
  logic [7:0]        digit_enable_mask;
  logic [7:0]        dim_enable_mask;
  logic [7:0]        half_bright_mask;
  logic [2:0]        current_digit;
  logic [1:0]        scan_count;
  logic [DIGITS-1:0] seg_valid;
  logic [2:0]        pend_digit;
  logic              pend_test;
  logic              pend_valid;

  logic       accept_in;
  logic       do_write;
  logic       go_read;
  logic       load_out;
  lds_sel_t   sel;
  logic [7:0] rdata;
  logic [7:0] seg_next;
  logic       blank_now;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept_in = in_valid && in_ready;
  assign do_write  = accept_in && (in_data.action == ACT_WRITE)
                     && ({1'b0, in_data.digit_index} < 4'(DIGITS));
  assign go_read   = accept_in && (in_data.action == ACT_TICK) && sel.found;
  assign load_out  = (state == ST_READ) && (!out_valid || out_ready);

  lds_scan #(.DIGITS(DIGITS)) u_scan (
    .cur_digit   (current_digit),
    .enable_mask (digit_enable_mask),
    .hold        (in_data.hold_at_wrap),
    .sel         (sel)
  );

  lds_ram #(.WIDTH(8), .DEPTH(DIGITS)) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (in_data.digit_index[AW-1:0]),
    .wdata (in_data.segment_value),
    .re    (go_read),
    .raddr (sel.digit[AW-1:0]),
    .rdata (rdata)
  );

  // dimmed digits blank on odd scans (half) or three of four (quarter)
  always_comb begin
    blank_now = 1'b0;
    if (dim_enable_mask[pend_digit]) begin
      if (half_bright_mask[pend_digit]) begin
        blank_now = scan_count[0];
      end else begin
        blank_now = (scan_count != 2'd0);
      end
    end
    if (blank_now) begin
      seg_next = SEG_BLANK;
    end else if (pend_test) begin
      seg_next = SEG_ALL_ON;
    end else if (pend_valid) begin
      seg_next = rdata;
    end else begin
      seg_next = SEG_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_enable_mask <= '0;
      dim_enable_mask   <= '0;
      half_bright_mask  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIGIT_EN: digit_enable_mask <= cfg_data;
        REG_DIM_EN:   dim_enable_mask   <= cfg_data;
        REG_HALF_BRT: half_bright_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_digit <= '0;
      scan_count    <= '0;
      seg_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (do_write) begin
        seg_valid[in_data.digit_index[AW-1:0]] <= 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (go_read) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (load_out) begin
            out_valid     <= 1'b1;
            current_digit <= pend_digit;
            scan_count    <= scan_count + 2'd1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go_read) begin
      pend_digit <= sel.digit;
      pend_test  <= in_data.test_mode;
      pend_valid <= seg_valid[sel.digit[AW-1:0]];
    end
    if (load_out) begin
      out_data.blank_digit   <= current_digit;
      out_data.segment_drive <= seg_next;
      out_data.active_digit  <= pend_digit;
    end
  end

  a_active_tracks_current: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_data.active_digit == current_digit)
    else $error("active digit differs from current digit");

  a_blank_is_previous: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_data.blank_digit == $past(current_digit))
    else $error("blank digit is not the previously driven digit");

  a_scan_count_steps: assert property (@(posedge clk) disable iff (rst)
    load_out |=> scan_count == $past(scan_count) + 2'd1)
    else $error("scan count did not advance by one");

  a_digit_in_range: assert property (@(posedge clk) disable iff (rst)
    load_out |=> {1'b0, out_data.active_digit} < 4'(DIGITS))
    else $error("active digit beyond digit count");

endmodule
